// File: sv/dwfs_pkg.sv
// ----------------------------------------------------------------------------
// dwfs_pkg
// Shared constants for the display window fill sequencer: display command
// codes, register map, register reset values and default panel limits.
// ----------------------------------------------------------------------------
package dwfs_pkg;

  // Largest panel side the clipping logic supports (default of the parameter)
  localparam int MAX_PANEL_SIDE = 1024;

  // Panel size register width
  localparam int PANEL_REG_W = 11;

  // Display controller command bytes
  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index (paddr[2]) codes
  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [PANEL_REG_W-1:0] PANEL_WIDTH_RST  = 11'd240;
  localparam logic [PANEL_REG_W-1:0] PANEL_HEIGHT_RST = 11'd320;

  // Input item kinds
  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage

// File: sv/dwfs_clip.sv
// ----------------------------------------------------------------------------
// dwfs_clip
// Checks a fill request against the panel and clips the rectangle so that
// it ends no later than the last column and row. Pure combinational.
// ----------------------------------------------------------------------------
module dwfs_clip #(
  parameter int MAX_PANEL_SIDE = dwfs_pkg::MAX_PANEL_SIDE,
  localparam int CW = $clog2(MAX_PANEL_SIDE),
  localparam int SW = $clog2(MAX_PANEL_SIDE + 1)
) (
  input  logic [15:0]                      origin_x,
  input  logic [15:0]                      origin_y,
  input  logic [15:0]                      rect_width,
  input  logic [15:0]                      rect_height,
  input  logic [dwfs_pkg::PANEL_REG_W-1:0] panel_width,
  input  logic [dwfs_pkg::PANEL_REG_W-1:0] panel_height,
  output logic                             fill_ok,
  output logic [CW-1:0]                    col_start,
  output logic [CW-1:0]                    col_end,
  output logic [CW-1:0]                    row_start,
  output logic [CW-1:0]                    row_end,
  output logic [SW-1:0]                    clip_w,
  output logic [SW-1:0]                    clip_h
);

  localparam logic [16:0] MaxSide17 = 17'(MAX_PANEL_SIDE);

  logic [16:0] pw;
  logic [16:0] ph;
  logic [16:0] x_end;
  logic [16:0] y_end;
  logic [16:0] w_room;
  logic [16:0] h_room;
  logic        x_over;
  logic        y_over;

  // Saturate panel registers to the supported side
  always_comb begin
    pw = 17'(panel_width);
    ph = 17'(panel_height);
    if (pw > MaxSide17) begin
      pw = MaxSide17;
    end
    if (ph > MaxSide17) begin
      ph = MaxSide17;
    end
  end

  // Acceptance: non-empty and origin on the panel
  assign fill_ok = (rect_width != 16'd0) && (rect_height != 16'd0) &&
                   (17'(origin_x) < pw) && (17'(origin_y) < ph);

  // Exclusive end points and the room left on the panel
  assign x_end  = 17'(origin_x) + 17'(rect_width);
  assign y_end  = 17'(origin_y) + 17'(rect_height);
  assign w_room = pw - 17'(origin_x);
  assign h_room = ph - 17'(origin_y);
  assign x_over = x_end > pw;
  assign y_over = y_end > ph;

  // Clipped window; only meaningful when fill_ok
  always_comb begin
    col_start = origin_x[CW-1:0];
    row_start = origin_y[CW-1:0];
    if (x_over) begin
      clip_w  = w_room[SW-1:0];
      col_end = CW'(pw - 17'd1);
    end else begin
      clip_w  = rect_width[SW-1:0];
      col_end = CW'(x_end - 17'd1);
    end
    if (y_over) begin
      clip_h  = h_room[SW-1:0];
      row_end = CW'(ph - 17'd1);
    end else begin
      clip_h  = rect_height[SW-1:0];
      row_end = CW'(y_end - 17'd1);
    end
  end

endmodule

// File: sv/dwfs_seq.sv
// ----------------------------------------------------------------------------
// dwfs_seq
// Byte sequencer: holds the clipped window and color, steps through the
// address-window commands and streams the pixel bytes, one per tick.
// ----------------------------------------------------------------------------
module dwfs_seq #(
  parameter int MAX_PANEL_SIDE = dwfs_pkg::MAX_PANEL_SIDE,
  localparam int CW = $clog2(MAX_PANEL_SIDE),
  localparam int SW = $clog2(MAX_PANEL_SIDE + 1),
  localparam int PW = $clog2(MAX_PANEL_SIDE * MAX_PANEL_SIDE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic          kind,
  input  logic          fill_ok,
  input  logic [CW-1:0] col_start,
  input  logic [CW-1:0] col_end,
  input  logic [CW-1:0] row_start,
  input  logic [CW-1:0] row_end,
  input  logic [SW-1:0] clip_w,
  input  logic [SW-1:0] clip_h,
  input  logic [15:0]   fill_color,
  output logic          emit,
  output logic [7:0]    emit_byte,
  output logic          emit_data,
  output logic          emit_tend,
  output logic          emit_last
);

  // Sequence steps
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_COL_CMD  = 4'd1;
  localparam logic [3:0] STEP_XS_HI    = 4'd2;
  localparam logic [3:0] STEP_XS_LO    = 4'd3;
  localparam logic [3:0] STEP_XE_HI    = 4'd4;
  localparam logic [3:0] STEP_XE_LO    = 4'd5;
  localparam logic [3:0] STEP_ROW_CMD  = 4'd6;
  localparam logic [3:0] STEP_YS_HI    = 4'd7;
  localparam logic [3:0] STEP_YS_LO    = 4'd8;
  localparam logic [3:0] STEP_YE_HI    = 4'd9;
  localparam logic [3:0] STEP_YE_LO    = 4'd10;
  localparam logic [3:0] STEP_MEM_CMD  = 4'd11;
  localparam logic [3:0] STEP_PIXELS   = 4'd12;

  logic [3:0]    step_r,     step_nxt;
  logic [CW-1:0] xs_r,       xs_nxt;
  logic [CW-1:0] xe_r,       xe_nxt;
  logic [CW-1:0] ys_r,       ys_nxt;
  logic [CW-1:0] ye_r,       ye_nxt;
  logic [SW-1:0] cw_r,       cw_nxt;
  logic [SW-1:0] ch_r,       ch_nxt;
  logic [15:0]   color_r,    color_nxt;
  logic [PW-1:0] pix_left_r, pix_left_nxt;
  logic          low_next_r, low_next_nxt;

  logic [15:0]   xs_w;
  logic [15:0]   xe_w;
  logic [15:0]   ys_w;
  logic [15:0]   ye_w;
  logic          final_px;

  // Coordinates as big-endian 16-bit words
  assign xs_w = 16'(xs_r);
  assign xe_w = 16'(xe_r);
  assign ys_w = 16'(ys_r);
  assign ye_w = 16'(ye_r);
  assign final_px = (pix_left_r <= PW'(1));

  // Next state and emitted byte
  always_comb begin
    step_nxt     = step_r;
    xs_nxt       = xs_r;
    xe_nxt       = xe_r;
    ys_nxt       = ys_r;
    ye_nxt       = ye_r;
    cw_nxt       = cw_r;
    ch_nxt       = ch_r;
    color_nxt    = color_r;
    pix_left_nxt = pix_left_r;
    low_next_nxt = low_next_r;
    emit         = 1'b0;
    emit_byte    = 8'h00;
    emit_data    = 1'b1;
    emit_tend    = 1'b0;
    emit_last    = 1'b0;

    if (go && kind == dwfs_pkg::KIND_FILL) begin
      // New request, taken only when idle, non-empty and inside the panel
      if (step_r == STEP_IDLE && fill_ok) begin
        xs_nxt       = col_start;
        xe_nxt       = col_end;
        ys_nxt       = row_start;
        ye_nxt       = row_end;
        cw_nxt       = clip_w;
        ch_nxt       = clip_h;
        color_nxt    = fill_color;
        low_next_nxt = 1'b0;
        step_nxt     = STEP_COL_CMD;
      end
    end else if (go) begin
      // Byte tick
      emit     = 1'b1;
      step_nxt = step_r + 4'd1;
      case (step_r)
        STEP_COL_CMD: begin
          emit_byte = dwfs_pkg::CMD_COLUMN;
          emit_data = 1'b0;
          emit_tend = 1'b1;
        end
        STEP_XS_HI: emit_byte = xs_w[15:8];
        STEP_XS_LO: begin
          emit_byte = xs_w[7:0];
          emit_tend = 1'b1;
        end
        STEP_XE_HI: emit_byte = xe_w[15:8];
        STEP_XE_LO: begin
          emit_byte = xe_w[7:0];
          emit_tend = 1'b1;
        end
        STEP_ROW_CMD: begin
          emit_byte = dwfs_pkg::CMD_ROW;
          emit_data = 1'b0;
          emit_tend = 1'b1;
        end
        STEP_YS_HI: emit_byte = ys_w[15:8];
        STEP_YS_LO: begin
          emit_byte = ys_w[7:0];
          emit_tend = 1'b1;
        end
        STEP_YE_HI: emit_byte = ye_w[15:8];
        STEP_YE_LO: begin
          emit_byte = ye_w[7:0];
          emit_tend = 1'b1;
        end
        STEP_MEM_CMD: begin
          emit_byte = dwfs_pkg::CMD_MEMWRITE;
          emit_data = 1'b0;
          emit_tend = 1'b1;
          // Pixel count, ready long before the first low byte
          pix_left_nxt = PW'(cw_r * ch_r);
        end
        STEP_PIXELS: begin
          step_nxt = STEP_PIXELS;
          if (!low_next_r) begin
            emit_byte    = color_r[15:8];
            low_next_nxt = 1'b1;
          end else begin
            emit_byte    = color_r[7:0];
            emit_tend    = final_px;
            emit_last    = final_px;
            low_next_nxt = 1'b0;
            if (final_px) begin
              pix_left_nxt = '0;
              step_nxt     = STEP_IDLE;
            end else begin
              pix_left_nxt = pix_left_r - PW'(1);
            end
          end
        end
        default: begin
          // Idle or unused step: no byte
          emit     = 1'b0;
          step_nxt = STEP_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_IDLE;
      xs_r       <= '0;
      xe_r       <= '0;
      ys_r       <= '0;
      ye_r       <= '0;
      cw_r       <= '0;
      ch_r       <= '0;
      color_r    <= '0;
      pix_left_r <= '0;
      low_next_r <= 1'b0;
    end else begin
      step_r     <= step_nxt;
      xs_r       <= xs_nxt;
      xe_r       <= xe_nxt;
      ys_r       <= ys_nxt;
      ye_r       <= ye_nxt;
      cw_r       <= cw_nxt;
      ch_r       <= ch_nxt;
      color_r    <= color_nxt;
      pix_left_r <= pix_left_nxt;
      low_next_r <= low_next_nxt;
    end
  end

endmodule

// File: sv/display_window_fill_sequencer_core.sv
// ----------------------------------------------------------------------------
// display_window_fill_sequencer_core
// Rectangle fill sequencer for a serial display with an address window.
// ----------------------------------------------------------------------------
// A request (in_kind = 0) loads a fill rectangle; it is dropped if empty, off
// the panel or sent while a fill is running, and never produces a byte. Each
// tick request (in_kind = 1) then yields one serial byte: column command, x
// start/end words, row command, y start/end words, memory-write command, and
// clipped width*height pixels, high byte first. Ticks while idle produce
// nothing. An accepted request goes into an input register and is processed
// into the output register once that is free; one request is taken every
// cycle while out_ready stays high. Panel size registers sit at byte
// addresses 0 (width) and 4 (height); clipping caps them at MAX_PANEL_SIDE.
// ----------------------------------------------------------------------------
module display_window_fill_sequencer_core #(
  parameter int MAX_PANEL_SIDE = dwfs_pkg::MAX_PANEL_SIDE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [15:0]                    in_origin_x,
  input  logic [15:0]                    in_origin_y,
  input  logic [15:0]                    in_rect_width,
  input  logic [15:0]                    in_rect_height,
  input  logic [15:0]                    in_fill_color,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_is_data,
  output logic                           out_transaction_end,
  output logic                           out_last_byte,
  // Configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dwfs_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [dwfs_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [dwfs_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CW = $clog2(MAX_PANEL_SIDE);
  localparam int SW = $clog2(MAX_PANEL_SIDE + 1);
  localparam int RW = dwfs_pkg::PANEL_REG_W;

  // Configuration registers
  logic [RW-1:0] panel_w_r;
  logic [RW-1:0] panel_h_r;
  logic          cfg_wr;

  // Input register
  logic          in_full_r,  in_full_nxt;
  logic          kind_r;
  logic [15:0]   x_r;
  logic [15:0]   y_r;
  logic [15:0]   w_r;
  logic [15:0]   h_r;
  logic [15:0]   color_r;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    byte_r;
  logic          data_r;
  logic          tend_r;
  logic          last_r;

  // Datapath
  logic          advance;
  logic          out_free;
  logic          fill_ok;
  logic [CW-1:0] col_start;
  logic [CW-1:0] col_end;
  logic [CW-1:0] row_start;
  logic [CW-1:0] row_end;
  logic [SW-1:0] clip_w;
  logic [SW-1:0] clip_h;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_data;
  logic          emit_tend;
  logic          emit_last;

  // APB register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_w_r <= dwfs_pkg::PANEL_WIDTH_RST;
      panel_h_r <= dwfs_pkg::PANEL_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == dwfs_pkg::REG_PANEL_WIDTH) begin
        panel_w_r <= cfg_pwdata[RW-1:0];
      end else begin
        panel_h_r <= cfg_pwdata[RW-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == dwfs_pkg::REG_PANEL_HEIGHT) begin
      cfg_prdata = dwfs_pkg::APB_DATA_W'(panel_h_r);
    end else begin
      cfg_prdata = dwfs_pkg::APB_DATA_W'(panel_w_r);
    end
  end

  // Handshake: the held request moves on when the output slot is free
  assign out_free    = !out_valid_r || out_ready;
  assign advance     = in_full_r && out_free;
  assign in_ready    = !in_full_r || advance;
  assign in_full_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_full_r);

  always_comb begin
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      x_r     <= in_origin_x;
      y_r     <= in_origin_y;
      w_r     <= in_rect_width;
      h_r     <= in_rect_height;
      color_r <= in_fill_color;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      byte_r <= emit_byte;
      data_r <= emit_data;
      tend_r <= emit_tend;
      last_r <= emit_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = byte_r;
  assign out_is_data         = data_r;
  assign out_transaction_end = tend_r;
  assign out_last_byte       = last_r;

  // Window check and clipping
  dwfs_clip #(
    .MAX_PANEL_SIDE (MAX_PANEL_SIDE)
  ) u_clip (
    .origin_x     (x_r),
    .origin_y     (y_r),
    .rect_width   (w_r),
    .rect_height  (h_r),
    .panel_width  (panel_w_r),
    .panel_height (panel_h_r),
    .fill_ok      (fill_ok),
    .col_start    (col_start),
    .col_end      (col_end),
    .row_start    (row_start),
    .row_end      (row_end),
    .clip_w       (clip_w),
    .clip_h       (clip_h)
  );

  // Byte sequencer
  dwfs_seq #(
    .MAX_PANEL_SIDE (MAX_PANEL_SIDE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (advance),
    .kind       (kind_r),
    .fill_ok    (fill_ok),
    .col_start  (col_start),
    .col_end    (col_end),
    .row_start  (row_start),
    .row_end    (row_end),
    .clip_w     (clip_w),
    .clip_h     (clip_h),
    .fill_color (color_r),
    .emit       (emit),
    .emit_byte  (emit_byte),
    .emit_data  (emit_data),
    .emit_tend  (emit_tend),
    .emit_last  (emit_last)
  );

endmodule

// File: verif/display_window_fill_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_window_fill_sequencer_core_tb
// Self-checking bench for the rectangle fill sequencer. A scoreboard class
// keeps its own copy of the panel registers and sequencing state, predicts
// each serial byte from the accepted requests and compares every result
// field. Directed corner cases are followed by random fill sequences over
// several panel sizes, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module display_window_fill_sequencer_core_tb;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_TOTAL   = 680;
  localparam int NUM_PHASES    = 8;

  // Position in the command/parameter/pixel byte sequence
  typedef enum logic [4:0] {
    ST_IDLE, ST_COL_CMD, ST_COL_START_HI, ST_COL_START_LO, ST_COL_END_HI,
    ST_COL_END_LO, ST_ROW_CMD, ST_ROW_START_HI, ST_ROW_START_LO, ST_ROW_END_HI,
    ST_ROW_END_LO, ST_MEMWRITE_CMD, ST_PIXELS
  } seq_step_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;
  } fill_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       transaction_end;
    logic       last_byte;
  } spi_byte_t;

  // Predicts the serial byte stream and checks what the block sends
  class fill_scoreboard;
    logic [dwfs_pkg::PANEL_REG_W-1:0] panel_w_reg = dwfs_pkg::PANEL_WIDTH_RST;
    logic [dwfs_pkg::PANEL_REG_W-1:0] panel_h_reg = dwfs_pkg::PANEL_HEIGHT_RST;
    seq_step_t   step = ST_IDLE;
    logic [9:0]  col_first = '0;
    logic [9:0]  col_last = '0;
    logic [9:0]  row_first = '0;
    logic [9:0]  row_last = '0;
    logic [15:0] color = '0;
    logic [20:0] pixels_left = '0;
    logic        low_next = 1'b0;
    spi_byte_t   pending_bytes[$];
    int          fail_count = 0;

    function void set_panel(logic reg_idx, logic [dwfs_pkg::PANEL_REG_W-1:0] value);
      if (reg_idx == dwfs_pkg::REG_PANEL_WIDTH) panel_w_reg = value;
      else panel_h_reg = value;
    endfunction

    // Panel registers saturate for clipping
    function int unsigned clip_side(logic [dwfs_pkg::PANEL_REG_W-1:0] r);
      return (r > dwfs_pkg::MAX_PANEL_SIDE) ? dwfs_pkg::MAX_PANEL_SIDE : int'(r);
    endfunction

    function int unsigned side_w();
      return clip_side(panel_w_reg);
    endfunction

    function int unsigned side_h();
      return clip_side(panel_h_reg);
    endfunction

    function bit busy();
      return step != ST_IDLE;
    endfunction

    function void queue_byte(logic [7:0] b, logic d, logic t, logic l);
      pending_bytes.push_back('{b, d, t, l});
    endfunction

    // Update state for one accepted request, queue the byte it yields
    function void take_request(fill_req_t r);
      int unsigned pw;
      int unsigned ph;
      int unsigned cw;
      int unsigned ch;
      logic        closing_px;
      if (r.kind == dwfs_pkg::KIND_FILL) begin
        pw = side_w();
        ph = side_h();
        // busy, empty or off-panel fills are dropped
        if (step != ST_IDLE || r.rect_width == 0 || r.rect_height == 0) return;
        if (r.origin_x >= pw || r.origin_y >= ph) return;
        cw = r.rect_width;
        ch = r.rect_height;
        if (r.origin_x + cw > pw) cw = pw - r.origin_x;
        if (r.origin_y + ch > ph) ch = ph - r.origin_y;
        col_first   = r.origin_x[9:0];
        col_last    = 10'(r.origin_x + cw - 1);
        row_first   = r.origin_y[9:0];
        row_last    = 10'(r.origin_y + ch - 1);
        color       = r.fill_color;
        pixels_left = 21'(cw * ch);
        low_next    = 1'b0;
        step        = ST_COL_CMD;
        return;
      end
      case (step)
        ST_IDLE:         return;
        ST_COL_CMD:      queue_byte(dwfs_pkg::CMD_COLUMN, 1'b0, 1'b1, 1'b0);
        ST_COL_START_HI: queue_byte({6'd0, col_first[9:8]}, 1'b1, 1'b0, 1'b0);
        ST_COL_START_LO: queue_byte(col_first[7:0], 1'b1, 1'b1, 1'b0);
        ST_COL_END_HI:   queue_byte({6'd0, col_last[9:8]}, 1'b1, 1'b0, 1'b0);
        ST_COL_END_LO:   queue_byte(col_last[7:0], 1'b1, 1'b1, 1'b0);
        ST_ROW_CMD:      queue_byte(dwfs_pkg::CMD_ROW, 1'b0, 1'b1, 1'b0);
        ST_ROW_START_HI: queue_byte({6'd0, row_first[9:8]}, 1'b1, 1'b0, 1'b0);
        ST_ROW_START_LO: queue_byte(row_first[7:0], 1'b1, 1'b1, 1'b0);
        ST_ROW_END_HI:   queue_byte({6'd0, row_last[9:8]}, 1'b1, 1'b0, 1'b0);
        ST_ROW_END_LO:   queue_byte(row_last[7:0], 1'b1, 1'b1, 1'b0);
        ST_MEMWRITE_CMD: queue_byte(dwfs_pkg::CMD_MEMWRITE, 1'b0, 1'b1, 1'b0);
        ST_PIXELS: begin
          // pixel stream is one transaction, closed on the last low byte
          if (!low_next) begin
            queue_byte(color[15:8], 1'b1, 1'b0, 1'b0);
            low_next = 1'b1;
          end else begin
            closing_px = (pixels_left <= 1);
            queue_byte(color[7:0], 1'b1, closing_px, closing_px);
            low_next = 1'b0;
            if (closing_px) begin
              pixels_left = '0;
              step = ST_IDLE;
            end else begin
              pixels_left = pixels_left - 1'b1;
            end
          end
          return;
        end
        default: begin
          step = ST_IDLE;
          return;
        end
      endcase
      step = seq_step_t'(step + 5'd1);
    endfunction

    function void check_byte(spi_byte_t got);
      spi_byte_t want;
      if (pending_bytes.size() == 0) begin
        $error("out_byte %02h arrived with no byte expected", got.value);
        fail_count++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.value !== want.value) begin
        $error("out_byte: expected %02h, got %02h", want.value, got.value);
        fail_count++;
      end
      if (got.is_data !== want.is_data) begin
        $error("out_is_data: expected %0b, got %0b", want.is_data, got.is_data);
        fail_count++;
      end
      if (got.transaction_end !== want.transaction_end) begin
        $error("out_transaction_end: expected %0b, got %0b",
               want.transaction_end, got.transaction_end);
        fail_count++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("out_last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = dwfs_pkg::KIND_TICK;
  logic [15:0] in_origin_x = '0;
  logic [15:0] in_origin_y = '0;
  logic [15:0] in_rect_width = '0;
  logic [15:0] in_rect_height = '0;
  logic [15:0] in_fill_color = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_transaction_end;
  logic        out_last_byte;

  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [dwfs_pkg::APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [dwfs_pkg::APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [dwfs_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  fill_scoreboard sb;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  display_window_fill_sequencer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_origin_x         (in_origin_x),
    .in_origin_y         (in_origin_y),
    .in_rect_width       (in_rect_width),
    .in_rect_height      (in_rect_height),
    .in_fill_color       (in_fill_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_is_data         (out_is_data),
    .out_transaction_end (out_transaction_end),
    .out_last_byte       (out_last_byte),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("display_window_fill_sequencer_core_tb: FAIL");
      $finish;
    end
  end

  // Receiver with random stalls
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(1, 100) > recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    spi_byte_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_byte, out_is_data, out_transaction_end, out_last_byte};
      sb.check_byte(seen);
    end
  end

  function automatic fill_req_t random_req();
    fill_req_t r;
    r.kind        = 1'($urandom);
    r.origin_x    = 16'($urandom);
    r.origin_y    = 16'($urandom);
    r.rect_width  = 16'($urandom);
    r.rect_height = 16'($urandom);
    r.fill_color  = 16'($urandom);
    return r;
  endfunction

  // Pick origin and size on one axis so the clipped span is 'span', capped at 'side'
  function automatic void place_span(input int unsigned side, input int unsigned span,
                                     output logic [15:0] start, output logic [15:0] size);
    if (side == 0) begin
      start = 16'($urandom);
      size  = 16'($urandom_range(1, 65535));
      return;
    end
    if (span > side) span = side;
    case ($urandom_range(0, 3))
      0, 1: begin
        start = 16'($urandom_range(0, side - span));
        size  = 16'(span);
      end
      2: begin
        start = 16'(side - span);
        size  = 16'($urandom_range(span, 65535));
      end
      default: begin
        start = 16'(side - span);
        size  = 16'hFFFF;
      end
    endcase
  endfunction

  // Hold the request until accepted, then maybe leave a gap
  task automatic push_item(input fill_req_t r);
    in_valid       <= 1'b1;
    in_kind        <= r.kind;
    in_origin_x    <= r.origin_x;
    in_origin_y    <= r.origin_y;
    in_rect_width  <= r.rect_width;
    in_rect_height <= r.rect_height;
    in_fill_color  <= r.fill_color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_request(r);
    items_sent++;
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Tick until the running fill is done, with stray requests mixed in when noise_pct is nonzero
  task automatic run_out_fill(input int noise_pct);
    fill_req_t r;
    while (sb.busy()) begin
      r = random_req();
      if (noise_pct == 0 || $urandom_range(1, 100) > noise_pct) r.kind = dwfs_pkg::KIND_TICK;
      push_item(r);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a readback
  task automatic write_panel(input logic reg_idx,
                             input logic [dwfs_pkg::PANEL_REG_W-1:0] value);
    logic [dwfs_pkg::APB_DATA_W-1:0] wdata;
    wdata = dwfs_pkg::APB_DATA_W'(value);
    if ($urandom_range(0, 1)) begin
      wdata[dwfs_pkg::APB_DATA_W-1:dwfs_pkg::PANEL_REG_W] = 21'($urandom);
    end
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_panel(reg_idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== dwfs_pkg::APB_DATA_W'(value)) begin
      $error("cfg_prdata: expected %0h, got %0h", value, cfg_prdata);
      sb.fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    fill_req_t    directed_reqs[10];
    fill_req_t    r;
    int unsigned  phase_w[NUM_PHASES];
    int unsigned  phase_h[NUM_PHASES];
    int unsigned  cw;
    int unsigned  ch;
    int           target;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at the reset panel size (240 x 320)
    directed_reqs = '{
      '{dwfs_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, // idle tick
      '{dwfs_pkg::KIND_FILL, 16'd0, 16'd0, 16'd0, 16'd5, 16'h1234},     // zero width
      '{dwfs_pkg::KIND_FILL, 16'd0, 16'd0, 16'd5, 16'd0, 16'h1234},     // zero height
      '{dwfs_pkg::KIND_FILL, 16'd240, 16'd0, 16'd1, 16'd1, 16'h1234},   // x off panel
      '{dwfs_pkg::KIND_FILL, 16'd0, 16'd320, 16'd1, 16'd1, 16'h1234},   // y off panel
      '{dwfs_pkg::KIND_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{dwfs_pkg::KIND_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF},     // single pixel
      '{dwfs_pkg::KIND_FILL, 16'd239, 16'd319, 16'hFFFF, 16'hFFFF, 16'h0000}, // corner
      '{dwfs_pkg::KIND_FILL, 16'd236, 16'd255, 16'hFFFF, 16'd3, 16'hA55A},    // clip width
      '{dwfs_pkg::KIND_FILL, 16'd235, 16'd318, 16'd5, 16'd2, 16'h5AA5}        // exact fit
    };
    foreach (directed_reqs[i]) begin
      push_item(directed_reqs[i]);
      // a well-formed fill while busy must be ignored
      if (sb.busy()) begin
        push_item('{dwfs_pkg::KIND_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0000});
      end
      run_out_fill(0);
    end

    // Random phases over panel sizes and idling mixes
    phase_w = '{240, 1, 2047, 1024, 0, 9, 1025, 0};
    phase_h = '{320, 1, 2047, 1024, 5, 0, 1000, 0};
    phase_w[NUM_PHASES-1] = $urandom_range(1, dwfs_pkg::MAX_PANEL_SIDE);
    phase_h[NUM_PHASES-1] = $urandom_range(1, dwfs_pkg::MAX_PANEL_SIDE);
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 48; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 48; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      write_panel(dwfs_pkg::REG_PANEL_WIDTH, dwfs_pkg::PANEL_REG_W'(phase_w[p]));
      write_panel(dwfs_pkg::REG_PANEL_HEIGHT, dwfs_pkg::PANEL_REG_W'(phase_h[p]));
      target = items_sent + ITEMS_TOTAL / NUM_PHASES;
      while (items_sent < target) begin
        r = random_req();
        if ($urandom_range(1, 100) <= 15) begin
          // idle noise: stray tick, empty fill or off-panel origin
          case ($urandom_range(0, 2))
            0: r.kind = dwfs_pkg::KIND_TICK;
            1: begin
              r.kind = dwfs_pkg::KIND_FILL;
              if ($urandom_range(0, 1)) r.rect_width = '0;
              else r.rect_height = '0;
            end
            default: begin
              r.kind = dwfs_pkg::KIND_FILL;
              if ($urandom_range(0, 1)) r.origin_x = 16'($urandom_range(sb.side_w(), 65535));
              else r.origin_y = 16'($urandom_range(sb.side_h(), 65535));
            end
          endcase
          push_item(r);
        end else begin
          // well-formed fill, mostly tiny, one side occasionally longer
          r.kind = dwfs_pkg::KIND_FILL;
          cw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 3);
          ch = (cw <= 3 && $urandom_range(0, 9) == 0) ? $urandom_range(1, 24)
                                                      : $urandom_range(1, 3);
          place_span(sb.side_w(), cw, r.origin_x, r.rect_width);
          place_span(sb.side_h(), ch, r.origin_y, r.rect_height);
          push_item(r);
          run_out_fill(5);
        end
      end
    end

    settle();
    if (sb.fail_count == 0) begin
      $display("display_window_fill_sequencer_core_tb: PASS");
    end else begin
      $display("display_window_fill_sequencer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
